// ===== hw/rtl/fps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame pacing scheduler package
// Command codes, register indexes, tally slots and rate constants.
// ----------------------------------------------------------------------------
package fps_pkg;

   localparam int INDEX_WIDTH_DEF = 16;
   localparam int TALLY_WIDTH_DEF = 32;

   localparam int FPS_WIDTH    = 16;
   localparam int PERIOD_WIDTH = 10;
   localparam int TIME_WIDTH   = 32;
   localparam int CSR_IDX_W    = 2;

   localparam int FPS_LOW    = 1;
   localparam int FPS_HIGH   = 1000;
   localparam int MS_PER_SEC = 1000;
   localparam int FPS_RESET  = 30;

   // divider operand widths: numerator up to 1000 + 500
   localparam int DIV_NUM_W = 11;
   localparam int DIV_DEN_W = 10;

   localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET =
      PERIOD_WIDTH'((MS_PER_SEC + FPS_RESET / 2) / FPS_RESET);

   typedef enum logic [2:0] {
      CMD_POLL     = 3'd0,
      CMD_COMPLETE = 3'd1,
      CMD_RESTART  = 3'd2,
      CMD_START    = 3'd3,
      CMD_STOP     = 3'd4,
      CMD_REWIND   = 3'd5
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FPS       = 2'd0,
      CSR_STREAMING = 2'd1,
      CSR_CLIP_LEN  = 2'd2
   } csr_idx_type;

   localparam int T_SENT    = 0;
   localparam int T_FAILED  = 1;
   localparam int T_LATE    = 2;
   localparam int T_STARVED = 3;
   localparam int T_LOOP    = 4;
   localparam int T_COUNT   = 5;

endpackage : fps_pkg
`default_nettype wire

// ===== hw/rtl/frame_pacing_scheduler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame pacing scheduler
// Paces frame sends on an absolute millisecond schedule with overrun resync.
// ----------------------------------------------------------------------------
// Each command item (poll, complete, restart, start, stop, rewind) gives
// exactly one result item, registered and valid in the cycle after the item
// is taken; items may be sent back to back, and a new item is taken in the
// same cycle the pending result is taken. The only exception is a write to
// frames_per_second: the period round(1000/fps) is then worked out by a
// radix-2 restoring divider, one quotient bit per cycle, and req_tready stays
// low after the write until the new period is in place. The deadline compare
// is wrap-safe (sign of now - deadline), so now_ms may wrap freely. Result
// items carry the due flag, the clip frame index and the five running tallies
// and run state as they stand after the item.
// ----------------------------------------------------------------------------
module frame_pacing_scheduler
   import fps_pkg::*;
#(
   parameter int INDEX_WIDTH = INDEX_WIDTH_DEF,
   parameter int TALLY_WIDTH = TALLY_WIDTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,

   // command items
   input  wire logic                 req_tvalid,
   output      logic                 req_tready,
   // [31:0] now_ms, [32] source_empty, [33] send_ok, [39:34] zero
   input  wire logic [39:0]          req_tdata,
   // [2:0] cmd
   input  wire logic [2:0]           req_tuser,

   // result items
   output      logic                 rsp_tvalid,
   input  wire logic                 rsp_tready,
   // [0] due, [16:1] frame_index, [48:17] sent_count, [80:49] failed_count,
   // [112:81] late_count, [144:113] starved_count, [176:145] loop_count,
   // [177] is_running, [183:178] zero
   output      logic [183:0]         rsp_tdata,

   // configuration writes
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [FPS_WIDTH-1:0] csr_wdata
);

   // ------------------------------------------------------------------------
   // Configuration registers (the rate lives on as period_ff)
   // ------------------------------------------------------------------------
   logic                    streaming_ff;
   logic [FPS_WIDTH-1:0]    clip_len_ff;

   // ------------------------------------------------------------------------
   // Schedule state
   // ------------------------------------------------------------------------
   logic [TIME_WIDTH-1:0]   deadline_ff,  deadline_in;
   logic [PERIOD_WIDTH-1:0] period_ff;
   logic [INDEX_WIDTH-1:0]  position_ff,  position_in;
   logic                    active_ff,    active_in;
   logic                    awaiting_ff,  awaiting_in;
   logic [TALLY_WIDTH-1:0]  tally_ff [T_COUNT];
   logic [TALLY_WIDTH-1:0]  tally_in [T_COUNT];

   // result register (status fields are read straight from the state above)
   logic                    rsp_valid_ff;
   logic                    due_ff,       due_in;
   logic [INDEX_WIDTH-1:0]  index_ff,     index_in;

   // period divider
   logic                    div_busy_ff;
   logic [3:0]              div_cnt_ff;
   logic [DIV_NUM_W-1:0]    div_num_ff;   // numerator in, quotient out
   logic [DIV_DEN_W-1:0]    div_den_ff;
   logic [DIV_DEN_W-1:0]    div_rem_ff;

   // ------------------------------------------------------------------------
   // Handshake
   // ------------------------------------------------------------------------
   logic req_accept;

   assign req_tready = !div_busy_ff && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   // ------------------------------------------------------------------------
   // Item fields
   // ------------------------------------------------------------------------
   cmd_type               cmd;
   logic [TIME_WIDTH-1:0] now_ms;
   logic                  source_empty;
   logic                  send_ok;

   assign cmd          = cmd_type'(req_tuser);
   assign now_ms       = req_tdata[31:0];
   assign source_empty = req_tdata[32];
   assign send_ok      = req_tdata[33];

   // ------------------------------------------------------------------------
   // Slot arithmetic
   // ------------------------------------------------------------------------
   logic [TIME_WIDTH-1:0]  since_deadline;
   logic                   deadline_hit;
   logic [TIME_WIDTH-1:0]  slot_deadline;
   logic [TIME_WIDTH-1:0]  since_next;
   logic                   overrun;
   logic [TIME_WIDTH-1:0]  resync_deadline;
   logic [INDEX_WIDTH-1:0] position_inc;
   logic                   clip_wrap;
   logic                   clip_empty;

   assign since_deadline  = now_ms - deadline_ff;
   assign deadline_hit    = !since_deadline[TIME_WIDTH-1];
   assign slot_deadline   = deadline_ff + TIME_WIDTH'(period_ff);
   assign since_next      = now_ms - slot_deadline;
   assign overrun         = !since_next[TIME_WIDTH-1];
   assign resync_deadline = now_ms + TIME_WIDTH'(period_ff);
   assign position_inc    = position_ff + INDEX_WIDTH'(1);
   assign clip_wrap       = 32'(position_inc) >= 32'(clip_len_ff);
   assign clip_empty      = (clip_len_ff == '0);

   // ------------------------------------------------------------------------
   // Step logic
   // ------------------------------------------------------------------------
   always_comb begin
      deadline_in = deadline_ff;
      position_in = position_ff;
      active_in   = active_ff;
      awaiting_in = awaiting_ff;
      due_in      = 1'b0;
      index_in    = '0;
      for (int k = 0; k < T_COUNT; k++) begin
         tally_in[k] = tally_ff[k];
      end

      case (cmd)
         CMD_POLL: begin
            if (active_ff && !awaiting_ff && !(!streaming_ff && clip_empty)
                && deadline_hit) begin
               if (streaming_ff && source_empty) begin
                  // starved slot: consume it without a send
                  tally_in[T_STARVED] = tally_ff[T_STARVED] + TALLY_WIDTH'(1);
                  deadline_in = slot_deadline;
                  if (overrun) begin
                     tally_in[T_LATE] = tally_ff[T_LATE] + TALLY_WIDTH'(1);
                     deadline_in      = resync_deadline;
                  end
               end else begin
                  due_in      = 1'b1;
                  index_in    = streaming_ff ? '0 : position_ff;
                  awaiting_in = 1'b1;
               end
            end
         end
         CMD_COMPLETE: begin
            if (awaiting_ff) begin
               awaiting_in = 1'b0;
               if (send_ok) begin
                  tally_in[T_SENT] = tally_ff[T_SENT] + TALLY_WIDTH'(1);
               end else begin
                  tally_in[T_FAILED] = tally_ff[T_FAILED] + TALLY_WIDTH'(1);
               end
               deadline_in = slot_deadline;
               if (overrun) begin
                  tally_in[T_LATE] = tally_ff[T_LATE] + TALLY_WIDTH'(1);
                  deadline_in      = resync_deadline;
               end
               if (!streaming_ff) begin
                  if (clip_empty) begin
                     position_in = '0;
                  end else if (clip_wrap) begin
                     position_in      = '0;
                     tally_in[T_LOOP] = tally_ff[T_LOOP] + TALLY_WIDTH'(1);
                  end else begin
                     position_in = position_inc;
                  end
               end
            end
         end
         CMD_RESTART: begin
            // period already tracks fps, so no re-derivation is needed here
            position_in = '0;
            active_in   = 1'b1;
            awaiting_in = 1'b0;
            deadline_in = now_ms;
            for (int k = 0; k < T_COUNT; k++) begin
               tally_in[k] = '0;
            end
         end
         CMD_START: begin
            if (!active_ff) begin
               active_in   = 1'b1;
               deadline_in = now_ms;
            end
         end
         CMD_STOP: begin
            active_in = 1'b0;
         end
         CMD_REWIND: begin
            position_in = '0;
            deadline_in = now_ms;
         end
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Period divider: (1000 + f/2) / f with f clamped to 1..1000
   // ------------------------------------------------------------------------
   logic [FPS_WIDTH-1:0] fps_clamped;
   logic [DIV_DEN_W-1:0] div_den_start;
   logic [DIV_NUM_W-1:0] div_num_start;
   logic [DIV_NUM_W-1:0] div_trial;
   logic                 div_take;
   logic                 fps_write;

   always_comb begin
      fps_clamped = csr_wdata;
      if (csr_wdata < FPS_WIDTH'(FPS_LOW)) begin
         fps_clamped = FPS_WIDTH'(FPS_LOW);
      end else if (csr_wdata > FPS_WIDTH'(FPS_HIGH)) begin
         fps_clamped = FPS_WIDTH'(FPS_HIGH);
      end
   end

   assign div_den_start = fps_clamped[DIV_DEN_W-1:0];
   assign div_num_start = DIV_NUM_W'(MS_PER_SEC) + DIV_NUM_W'(div_den_start >> 1);
   assign div_trial     = {div_rem_ff, div_num_ff[DIV_NUM_W-1]};
   assign div_take      = div_trial >= DIV_NUM_W'(div_den_ff);
   assign fps_write     = csr_we && (csr_index == CSR_FPS);

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
         div_cnt_ff  <= '0;
         period_ff   <= PERIOD_RESET;
      end else if (fps_write) begin
         div_busy_ff <= 1'b1;
         div_cnt_ff  <= 4'(DIV_NUM_W - 1);
      end else if (div_busy_ff) begin
         div_cnt_ff <= div_cnt_ff - 4'd1;
         if (div_cnt_ff == '0) begin
            div_busy_ff <= 1'b0;
            // last quotient bit joins the ones already shifted in
            period_ff   <= {div_num_ff[PERIOD_WIDTH-2:0], div_take};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fps_write) begin
         div_num_ff <= div_num_start;
         div_den_ff <= div_den_start;
         div_rem_ff <= '0;
      end else if (div_busy_ff) begin
         div_num_ff <= {div_num_ff[DIV_NUM_W-2:0], div_take};
         div_rem_ff <= div_take ? DIV_DEN_W'(div_trial - DIV_NUM_W'(div_den_ff))
                                : div_trial[DIV_DEN_W-1:0];
      end
   end

   // ------------------------------------------------------------------------
   // Configuration and state registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         streaming_ff <= 1'b0;
         clip_len_ff  <= '0;
         deadline_ff  <= '0;
         position_ff  <= '0;
         active_ff    <= 1'b0;
         awaiting_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < T_COUNT; k++) begin
            tally_ff[k] <= '0;
         end
      end else begin
         if (req_accept) begin
            deadline_ff  <= deadline_in;
            position_ff  <= position_in;
            active_ff    <= active_in;
            awaiting_ff  <= awaiting_in;
            rsp_valid_ff <= 1'b1;
            for (int k = 0; k < T_COUNT; k++) begin
               tally_ff[k] <= tally_in[k];
            end
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_we) begin
            case (csr_idx_type'(csr_index))
               CSR_FPS: begin
                  // taken up by the period divider
               end
               CSR_STREAMING: begin
                  streaming_ff <= csr_wdata[0];
               end
               CSR_CLIP_LEN: begin
                  clip_len_ff <= csr_wdata;
                  // shrinking the clip below the play point rewinds it
                  if (32'(position_ff) >= 32'(csr_wdata)) begin
                     position_ff <= '0;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         due_ff   <= due_in;
         index_ff <= index_in;
      end
   end

   // ------------------------------------------------------------------------
   // Result packing
   // ------------------------------------------------------------------------
   logic [31:0] index_ext;
   logic [63:0] tally_ext [T_COUNT];

   assign index_ext = 32'(index_ff);
   always_comb begin
      for (int k = 0; k < T_COUNT; k++) begin
         tally_ext[k] = 64'(tally_ff[k]);
      end
   end

   assign rsp_tdata = {6'd0,
                       active_ff,
                       tally_ext[T_LOOP][31:0],
                       tally_ext[T_STARVED][31:0],
                       tally_ext[T_LATE][31:0],
                       tally_ext[T_FAILED][31:0],
                       tally_ext[T_SENT][31:0],
                       index_ext[15:0],
                       due_ff};

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_no_accept_while_dividing: assert property (@(posedge clock) disable iff (reset)
      div_busy_ff |-> !req_tready)
      else $error("item taken while period is being derived");

   a_period_nonzero: assert property (@(posedge clock) disable iff (reset)
      !div_busy_ff |-> (period_ff != '0) && (period_ff <= PERIOD_WIDTH'(FPS_HIGH)))
      else $error("period out of range");

   a_due_sets_awaiting: assert property (@(posedge clock) disable iff (reset)
      req_accept && due_in |=> awaiting_ff && rsp_tvalid)
      else $error("due frame not marked as awaiting completion");

   a_stop_halts: assert property (@(posedge clock) disable iff (reset)
      req_accept && (cmd == CMD_STOP) |=> !active_ff)
      else $error("stop did not halt playback");

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      req_accept && (cmd == CMD_RESTART)
      |=> active_ff && !awaiting_ff && (tally_ff[T_SENT] == '0) && (position_ff == '0))
      else $error("restart did not clear state");

endmodule : frame_pacing_scheduler
`default_nettype wire
